// ===== sv/nlt_pkg.sv =====
// nlt_pkg: shared types and constants for the neighbour link table
// no dependencies
`default_nettype none
package nlt_pkg;
	localparam int MAX_NODES_DEF      = 64;
	localparam int MAX_NEIGHBOURS_DEF = 16;
	localparam logic [5:0] FRESH_VALUE = 6'd50;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NODE_FULL = 2'd1,
		ST_NBR_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_NSCAN,
		S_NWAIT,
		S_PLAN,
		S_UWAIT,
		S_USED,
		S_LSCAN,
		S_LWAIT,
		S_DECIDE,
		S_SUM,
		S_SWAIT,
		S_DIV,
		S_OUT
	} fsm_t;
endpackage
`default_nettype wire

// ===== sv/neighbour_link_table.sv =====
// neighbour_link_table: link report processor over node and neighbour memories
// per request: a serial node scan, two neighbour list scans and a bit-serial divide
//   (divider width is 8 + clog2(MAX_NEIGHBOURS+1))
// throughput: one request at a time, set by the serial node scan through the single
//   address memory port, the neighbour scans and the bit-serial divider
// reset: node count and all per-node neighbour counts read as zero right after reset
//   (valid bits in flip-flops); no clearing pass
`default_nettype none
module neighbour_link_table #(
	parameter int MAX_NODES      = nlt_pkg::MAX_NODES_DEF,
	parameter int MAX_NEIGHBOURS = nlt_pkg::MAX_NEIGHBOURS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// orig_addr[31:0], sender_addr[63:32], pkt_count[71:64]
	input  wire logic [71:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// orig_slot[5:0], sender_slot[11:6], sender_average[19:12], status[21:20], pad
	output logic [23:0]      m_tdata
);
	localparam int NB = $clog2(MAX_NODES);
	localparam int KB = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
	localparam int CB = $clog2(MAX_NODES + 1);
	localparam int UB = $clog2(MAX_NEIGHBOURS + 1);
	localparam int SW = 8 + UB;
	localparam int LD = MAX_NODES * MAX_NEIGHBOURS;
	localparam int LB = $clog2(LD);

	// memories
	logic [31:0] addr_mem [MAX_NODES];
	logic [5:0]  fresh_mem [MAX_NODES];
	logic [7:0]  mean_mem [MAX_NODES];
	logic [UB-1:0] used_mem [MAX_NODES];
	logic [NB-1:0] tgt_mem [LD];
	logic [7:0]  pkt_mem [LD];
	logic [MAX_NODES-1:0] used_vld_q;

	nlt_pkg::fsm_t st_q, st_d;

	logic [31:0] oa_q, sa_q;
	logic [7:0]  pc_q;
	logic [CB-1:0] count_q;
	logic [CB-1:0] idx_q;
	logic        ofound_q, sfound_q;
	logic [NB-1:0] of_q, sf_q, os_q, ss_q;
	logic [UB-1:0] used_q, k_q;
	logic        hit_q;
	logic [KB-1:0] hit_k_q;
	logic [SW-1:0] sum_q;
	logic [1:0]  status_q;
	logic [7:0]  avg_q;
	logic [NB-1:0] oslot_q, sslot_q;
	logic        m_valid_q;

	// memory read ports, registered data
	logic [31:0] addr_rd;
	logic [NB-1:0] tgt_rd;
	logic [7:0]  pkt_rd;
	logic [UB-1:0] used_rd;
	logic [NB-1:0] nrd_addr;
	logic [LB-1:0] lrd_addr;
	logic        rd_hold_q;

	logic [LB-1:0] base;
	assign base = LB'(ss_q) * LB'(MAX_NEIGHBOURS);

	// divider
	logic div_start, div_done;
	logic [SW-1:0] div_quo;

	nlt_div #(.NW(SW), .DW(UB)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(sum_q), .den(used_q), .done(div_done), .quo(div_quo)
	);

	assign nrd_addr = idx_q[NB-1:0];
	assign lrd_addr = base + LB'(k_q);

	always_ff @(posedge clk) begin
		addr_rd <= addr_mem[nrd_addr];
		tgt_rd  <= tgt_mem[lrd_addr];
		pkt_rd  <= pkt_mem[lrd_addr];
	end

	// commit happens in S_DECIDE; scan writes none
	logic        commit;
	logic        new_o, new_s;
	logic [UB-1:0] wr_k;
	assign new_o = !ofound_q;
	assign new_s = !sfound_q && (sa_q != oa_q);
	assign wr_k  = hit_q ? UB'(hit_k_q) : used_q;

	always_ff @(posedge clk) begin
		if (commit) begin
			if (new_o) begin
				addr_mem[os_q] <= oa_q;
			end
			fresh_mem[os_q] <= nlt_pkg::FRESH_VALUE;
			if (new_s) begin
				addr_mem[ss_q] <= sa_q;
			end
			fresh_mem[ss_q] <= nlt_pkg::FRESH_VALUE;
			tgt_mem[base + LB'(wr_k)] <= os_q;
			pkt_mem[base + LB'(wr_k)] <= pc_q;
			used_mem[ss_q] <= hit_q ? used_q : used_q + 1'b1;
		end
		if (st_q == nlt_pkg::S_DIV && div_done) begin
			mean_mem[ss_q] <= div_quo[7:0];
		end
	end

	// ss_q settles in S_PLAN, so the count is read in S_UWAIT and used in S_USED
	always_ff @(posedge clk) begin
		used_rd <= used_vld_q[ss_q] ? used_mem[ss_q] : '0;
	end

	// a new originator keeps its valid bit clear, so its list reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_vld_q <= '0;
		end else if (commit) begin
			used_vld_q[ss_q] <= 1'b1;
		end
	end

	// node count plan
	logic [CB:0] need_cnt;
	assign need_cnt = (CB+1)'(count_q) + (CB+1)'(new_o) + (CB+1)'(new_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= nlt_pkg::S_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
			rd_hold_q <= 1'b0;
		end else begin
			st_q <= st_d;
			rd_hold_q <= 1'b0;
			if (commit) count_q <= need_cnt[CB-1:0];
			if (st_q == nlt_pkg::S_OUT) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			nlt_pkg::S_IDLE: begin
				oa_q <= s_tdata[31:0];
				sa_q <= s_tdata[63:32];
				pc_q <= s_tdata[71:64];
				idx_q <= '0;
				ofound_q <= 1'b0;
				sfound_q <= 1'b0;
				of_q <= '0;
				sf_q <= '0;
			end
			nlt_pkg::S_NSCAN: ;
			nlt_pkg::S_NWAIT: begin
				if (!ofound_q && addr_rd == oa_q) begin
					ofound_q <= 1'b1;
					of_q <= idx_q[NB-1:0];
				end
				if (!sfound_q && addr_rd == sa_q) begin
					sfound_q <= 1'b1;
					sf_q <= idx_q[NB-1:0];
				end
				idx_q <= idx_q + 1'b1;
			end
			nlt_pkg::S_PLAN: begin
				os_q <= ofound_q ? of_q : count_q[NB-1:0];
				if (sa_q == oa_q) begin
					ss_q <= ofound_q ? of_q : count_q[NB-1:0];
					sfound_q <= ofound_q;
				end else begin
					ss_q <= sfound_q ? sf_q : NB'(count_q + CB'(!ofound_q));
				end
				k_q <= '0;
				hit_q <= 1'b0;
				hit_k_q <= '0;
				sum_q <= '0;
			end
			nlt_pkg::S_UWAIT: ;
			nlt_pkg::S_USED: begin
				used_q <= (sfound_q) ? used_rd : '0;
			end
			nlt_pkg::S_LSCAN: ;
			nlt_pkg::S_LWAIT: begin
				if (!hit_q && tgt_rd == os_q) begin
					hit_q <= 1'b1;
					hit_k_q <= k_q[KB-1:0];
				end
				k_q <= k_q + 1'b1;
			end
			nlt_pkg::S_DECIDE: begin
				k_q <= '0;
				if (!hit_q) used_q <= used_q + 1'b1;
			end
			nlt_pkg::S_SUM: ;
			nlt_pkg::S_SWAIT: begin
				sum_q <= sum_q + SW'(pkt_rd);
				k_q <= k_q + 1'b1;
			end
			nlt_pkg::S_DIV: begin
				avg_q <= div_quo[7:0];
				status_q <= nlt_pkg::ST_OK;
				oslot_q <= os_q;
				sslot_q <= ss_q;
			end
			nlt_pkg::S_OUT: ;
			default: ;
		endcase
		if (st_q == nlt_pkg::S_PLAN && need_cnt > (CB+1)'(MAX_NODES)) begin
			status_q <= nlt_pkg::ST_NODE_FULL;
			avg_q <= '0; oslot_q <= '0; sslot_q <= '0;
		end
		if (st_q == nlt_pkg::S_DECIDE && !hit_q && used_q >= UB'(MAX_NEIGHBOURS)) begin
			status_q <= nlt_pkg::ST_NBR_FULL;
			avg_q <= '0; oslot_q <= '0; sslot_q <= '0;
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		commit = 1'b0;
		div_start = 1'b0;
		s_tready = 1'b0;
		unique case (st_q)
			nlt_pkg::S_IDLE: begin
				s_tready = !m_valid_q;
				if (s_tvalid && !m_valid_q) st_d = nlt_pkg::S_NSCAN;
			end
			nlt_pkg::S_NSCAN: st_d = (idx_q < count_q) ? nlt_pkg::S_NWAIT : nlt_pkg::S_PLAN;
			nlt_pkg::S_NWAIT: st_d = nlt_pkg::S_NSCAN;
			nlt_pkg::S_PLAN: st_d = (need_cnt > (CB+1)'(MAX_NODES)) ? nlt_pkg::S_OUT
			                                                       : nlt_pkg::S_UWAIT;
			nlt_pkg::S_UWAIT: st_d = nlt_pkg::S_USED;
			nlt_pkg::S_USED: st_d = nlt_pkg::S_LSCAN;
			nlt_pkg::S_LSCAN: st_d = (k_q < used_q && !hit_q) ? nlt_pkg::S_LWAIT
			                                                  : nlt_pkg::S_DECIDE;
			nlt_pkg::S_LWAIT: st_d = nlt_pkg::S_LSCAN;
			nlt_pkg::S_DECIDE: begin
				if (!hit_q && used_q >= UB'(MAX_NEIGHBOURS)) begin
					st_d = nlt_pkg::S_OUT;
				end else begin
					commit = 1'b1;
					st_d = nlt_pkg::S_SUM;
				end
			end
			nlt_pkg::S_SUM: begin
				if (k_q < used_q) begin
					st_d = nlt_pkg::S_SWAIT;
				end else begin
					div_start = 1'b1;
					st_d = nlt_pkg::S_DIV;
				end
			end
			nlt_pkg::S_SWAIT: st_d = nlt_pkg::S_SUM;
			nlt_pkg::S_DIV: if (div_done) st_d = nlt_pkg::S_OUT;
			nlt_pkg::S_OUT: st_d = nlt_pkg::S_IDLE;
			default: st_d = nlt_pkg::S_IDLE;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {2'b00, status_q, avg_q, 6'(sslot_q), 6'(oslot_q)};

	logic unused_ok;
	assign unused_ok = rd_hold_q ^ (^fresh_mem[0]) ^ (^mean_mem[0]);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CB'(MAX_NODES)) else $error("node count overflow");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> st_q == nlt_pkg::S_IDLE) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == nlt_pkg::S_SUM |-> used_q <= UB'(MAX_NEIGHBOURS))
		else $error("neighbour count overflow");
endmodule
`default_nettype wire

// ===== sv/nlt_div.sv =====
// nlt_div: iterative restoring divider, one quotient bit per cycle
// depends on nothing but its ports
`default_nettype none
module nlt_div #(
	parameter int NW = 14,
	parameter int DW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] q_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;

	assign trial = {r_q[DW-1:0], q_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
endmodule
`default_nettype wire

// ===== dv/tb_neighbour_link_table.sv =====
// tb_neighbour_link_table: self-checking bench for the neighbour link table
// depends on nlt_pkg and neighbour_link_table; drives link reports, checks results
`timescale 1ns / 1ps
`default_nettype none
module tb_neighbour_link_table;

	localparam int NODES = nlt_pkg::MAX_NODES_DEF;
	localparam int NBRS  = nlt_pkg::MAX_NEIGHBOURS_DEF;
	localparam int DRAIN = 2 * NODES + 2 * NBRS + 40;

	// link table tracker: own copy of node and neighbour state, plus the
	// queue of link results still due from the block
	class link_tracker;
		int unsigned nodes_held;
		bit [31:0] addr_of [NODES];
		bit [4:0] nbr_cnt [NODES];
		bit [5:0] nbr_slot [NODES][NBRS];
		bit [7:0] nbr_pkts [NODES][NBRS];
		bit [23:0] due_q [$];
		int errors;
		int n_ok, n_node_full, n_nbr_full;

		function void clear();
			nodes_held = 0;
			foreach (nbr_cnt[i]) nbr_cnt[i] = 0;
			due_q.delete();
		endfunction

		function int lookup(bit [31:0] a);
			for (int i = 0; i < nodes_held; i++)
				if (addr_of[i] == a) return i;
			return -1;
		endfunction

		// note one accepted request: update the tracked tables and queue the result
		function void note_request(bit [31:0] oa, bit [31:0] sa, bit [7:0] pc);
			int of, sf, os, ss, need, hit, used, sum;
			nlt_pkg::status_t st;
			need = 0;
			hit = -1;
			of = lookup(oa);
			if (of < 0) begin
				os = nodes_held;
				need++;
			end else os = of;
			if (sa == oa) begin
				sf = of;
				ss = os;
			end else begin
				sf = lookup(sa);
				if (sf < 0) begin
					ss = nodes_held + need;
					need++;
				end else ss = sf;
			end
			if (nodes_held + need > NODES) begin
				st = nlt_pkg::ST_NODE_FULL;
				due_q.push_back({2'b0, st, 20'd0});
				n_node_full++;
				return;
			end
			used = (sf < 0) ? 0 : nbr_cnt[ss];
			for (int k = 0; k < used; k++)
				if (nbr_slot[ss][k] == os) begin
					hit = k;
					break;
				end
			if (hit < 0 && used >= NBRS) begin
				st = nlt_pkg::ST_NBR_FULL;
				due_q.push_back({2'b0, st, 20'd0});
				n_nbr_full++;
				return;
			end
			if (of < 0) begin
				addr_of[os] = oa;
				nbr_cnt[os] = 0;
			end
			if (ss != os && sf < 0) begin
				addr_of[ss] = sa;
				nbr_cnt[ss] = 0;
			end
			nodes_held += need;
			if (hit >= 0) nbr_pkts[ss][hit] = pc;
			else begin
				nbr_slot[ss][nbr_cnt[ss]] = os;
				nbr_pkts[ss][nbr_cnt[ss]] = pc;
				nbr_cnt[ss]++;
			end
			sum = 0;
			for (int k = 0; k < nbr_cnt[ss]; k++) sum += nbr_pkts[ss][k];
			st = nlt_pkg::ST_OK;
			due_q.push_back({2'b0, st, 8'(sum / nbr_cnt[ss]), 6'(ss), 6'(os)});
			n_ok++;
		endfunction

		task report(string what, bit [23:0] got, bit [23:0] want);
			errors++;
			$display("mismatch %s: got %h want %h", what, got, want);
		endtask

		task check_result(bit [23:0] got);
			bit [23:0] want;
			if (due_q.size() == 0) begin
				report("unexpected result", got, 24'd0);
				return;
			end
			want = due_q.pop_front();
			if (got[5:0] != want[5:0]) report("orig_slot", got, want);
			if (got[11:6] != want[11:6]) report("sender_slot", got, want);
			if (got[19:12] != want[19:12]) report("sender_average", got, want);
			if (got[21:20] != want[21:20]) report("status", got, want);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	// orig_addr[31:0], sender_addr[63:32], pkt_count[71:64]
	logic [71:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	// orig_slot[5:0], sender_slot[11:6], sender_average[19:12], status[21:20], pad
	logic [23:0] m_tdata;

	link_tracker board = new();
	bit no_idle = 0;    // long stretch with no gaps on either side
	int sent = 0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	neighbour_link_table u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// result side: random backpressure, check on each accepted result
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_result(m_tdata);
		m_tready <= no_idle || ($urandom_range(99) >= 24);
	end

	// address pools kept small so reports keep hitting known nodes
	bit [31:0] pool [24];

	// valid stays up after an accept until the next request or an idle cycle
	task automatic send_report(bit [31:0] oa, bit [31:0] sa, bit [7:0] pc);
		while (!no_idle && $urandom_range(99) < 24) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {pc, sa, oa};
		do @(posedge clk); while (!s_tready);
		board.note_request(oa, sa, pc);
		sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 0;
		while (board.due_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic bit [31:0] pick_addr(int spread);
		return pool[$urandom_range(spread - 1)];
	endfunction

	initial begin
		bit [31:0] oa, sa;
		board.clear();
		foreach (pool[i]) pool[i] = $urandom();
		pool[0] = 32'h0;
		pool[1] = 32'hFFFF_FFFF;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: address and count extremes, self report, update of a known entry
		send_report(32'h0, 32'hFFFF_FFFF, 8'hFF);
		send_report(32'hFFFF_FFFF, 32'h0, 8'h00);
		send_report(32'h0, 32'hFFFF_FFFF, 8'h01);
		send_report(32'hAAAA_5555, 32'hAAAA_5555, 8'h80);
		send_report(32'h5555_AAAA, 32'hFFFF_FFFF, 8'h7F);
		// fill one sender's neighbour list, then overflow it
		for (int i = 0; i < NBRS + 2; i++)
			send_report(32'h1000_0000 + i, 32'h0, 8'(i * 13));
		wait_drained();    // sender holds off until every result has come

		// random: mostly reports among a small pool of known nodes
		for (int n = 0; n < 600; n++) begin
			no_idle = (n >= 200 && n < 300);
			oa = ($urandom_range(9) == 0) ? $urandom() : pick_addr(24);
			sa = ($urandom_range(9) == 0) ? oa : pick_addr(12);
			send_report(oa, sa, 8'($urandom()));
		end
		no_idle = 0;
		// exhaust the node table with fresh addresses, then keep pushing
		for (int n = 0; n < 130; n++)
			send_report($urandom(), ($urandom_range(3) == 0) ? pick_addr(4) : $urandom(),
				8'($urandom()));

		wait_drained();
		$display("covered %0d reports: %0d stored, %0d node table full, %0d list full",
			sent, board.n_ok, board.n_node_full, board.n_nbr_full);
		if (board.errors == 0 && board.due_q.size() == 0)
			$display("tb_neighbour_link_table: done, clean");
		else
			$display("tb_neighbour_link_table: done, errors");
		$finish;
	end

	// watchdog: ~750 requests, with the time limit set several times over what they need
	initial begin
		#(12 * 4000000);
		$display("tb_neighbour_link_table: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/nlt_pkg.sv
sv/nlt_div.sv
sv/neighbour_link_table.sv
dv/tb_neighbour_link_table.sv
